>>> sv/mat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mat_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int THRESH_W   = 10;
    localparam int BASE_W     = 16;
    localparam int HOLD_W     = BASE_W + 2;

    // Averaging window
    localparam int WINDOW     = 5;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W      = $clog2(WINDOW * (2 ** SAMPLE_W - 1) + 1);

    // floor(sum / WINDOW) by reciprocal multiply, exact over the full sum range
    localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int AVG_RECIP   = (2 ** AVG_SHIFT + WINDOW - 1) / WINDOW;
    localparam int AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

    // floor(sum / WINDOW^2) equals floor(level / WINDOW)
    localparam int SQ_DIV      = WINDOW * WINDOW;
    localparam int SQ_SHIFT    = SUM_W + $clog2(SQ_DIV);
    localparam int SQ_RECIP    = (2 ** SQ_SHIFT + SQ_DIV - 1) / SQ_DIV;
    localparam int SQ_RECIP_W  = SQ_SHIFT + 1;
    localparam int SQ_PROD_W   = SUM_W + SQ_RECIP_W;

    // Stream and configuration ports
    localparam int IN_TDATA_W  = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_W + 1 + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = BASE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE      = 1'b1;

    // Reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd1;
    localparam logic [BASE_W-1:0]   BASE_RESET   = 16'd1500;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 18'd1500;

    // Holdoff multiple of the base after the clamp
    localparam logic [1:0] HOLD_X1 = 2'd1;
    localparam logic [1:0] HOLD_X2 = 2'd2;
    localparam logic [1:0] HOLD_X3 = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [1:0]          hold_mult;
    } t_win_info;

endpackage

`default_nettype wire

>>> sv/mat_window.sv
`timescale 1ns / 1ps
`default_nettype none

module mat_window
    import mat_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output t_win_info                o_info
);

    logic [SAMPLE_W-1:0]   r_ring [WINDOW];
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;

    logic [SLOT_W-1:0]     n_slot;
    logic [SUM_W-1:0]      n_sum;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SQ_PROD_W-1:0]  sq_prod;
    logic [SUM_W-1:0]      quot;
    logic [1:0]            hold_mult;

    // drop the oldest sample, add the new one
    assign n_sum = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(i_sample);

    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    assign avg_prod = AVG_PROD_W'(n_sum) * AVG_PROD_W'(AVG_RECIP);
    assign sq_prod  = SQ_PROD_W'(n_sum) * SQ_PROD_W'(SQ_RECIP);
    assign quot     = sq_prod[SQ_SHIFT +: SUM_W];

    // level at or below the window: one base; large multiples clamp to two
    always_comb begin
        if (quot == '0) begin
            hold_mult = HOLD_X1;
        end else if (quot > SUM_W'(HOLD_X3)) begin
            hold_mult = HOLD_X2;
        end else begin
            hold_mult = quot[1:0];
        end
    end

    assign o_info = {avg_prod[AVG_SHIFT +: SAMPLE_W], hold_mult};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_slot <= '0;
            r_sum  <= '0;
        end else if (i_adv) begin
            r_ring[r_slot] <= i_sample;
            r_slot         <= n_slot;
            r_sum          <= n_sum;
        end
    end

endmodule

`default_nettype wire

>>> sv/moving_average_trigger_holdoff.sv
`timescale 1ns / 1ps
`default_nettype none

// Sound-level trigger: each input item carries a 10-bit sample and the current
// millisecond time; each result item gives the floored average of the last five
// samples and a trigger flag. A trigger fires when the average is at or above
// the threshold register and more than the current holdoff has passed since the
// last trigger (time difference taken modulo 2^32). On a trigger the holdoff is
// reloaded as one, two or three times the base register, scaled by the average,
// so a base change only takes effect at the next trigger. Until five samples
// have arrived the empty slots count as zero. The block takes one item every
// clock cycle while the result stream is not stalled; each item passes through
// the input register, then the result register, where its result is presented,
// and the running sum, ring slot and trigger state all update in the single
// compute stage between them. A stalled output holds its result while one more
// item waits in the input register.

module moving_average_trigger_holdoff
    import mat_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample[9:0], now_ms[41:10]

    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // level[9:0], trigger[10]

    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    // configuration
    logic [THRESH_W-1:0] r_threshold;
    logic [BASE_W-1:0]   r_base;

    // input register
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic [TIME_W-1:0]   r_now;

    // result register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_level;
    logic                r_trigger;

    // trigger state
    logic [TIME_W-1:0]   r_last_ms;
    logic [HOLD_W-1:0]   r_holdoff;

    logic                out_adv;
    logic                calc;
    logic                in_acc;
    logic [TIME_W-1:0]   elapsed;
    logic                fire;
    logic [HOLD_W-1:0]   base_x1;
    logic [HOLD_W-1:0]   base_x2;
    logic [HOLD_W-1:0]   n_holdoff;
    t_win_info           win;

    // Advance the compute stage whenever the result register is free or drains
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign calc          = r_in_valid && out_adv;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    mat_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (calc),
        .i_sample (r_sample),
        .o_info   (win)
    );

    // Elapsed time wraps naturally in 32 bits
    assign elapsed = r_now - r_last_ms;
    assign fire    = (win.level >= r_threshold) && (elapsed > TIME_W'(r_holdoff));

    assign base_x1 = HOLD_W'(r_base);
    assign base_x2 = {1'b0, r_base, 1'b0};

    always_comb begin
        case (win.hold_mult)
            HOLD_X2: n_holdoff = base_x2;
            HOLD_X3: n_holdoff = base_x2 + base_x1;
            default: n_holdoff = base_x1;
        endcase
    end

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_base      <= BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THRESH_W-1:0];
                CFG_BASE:      r_base      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_now    <= s_axis_tdata[SAMPLE_W +: TIME_W];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc) begin
            r_level   <= win.level;
            r_trigger <= fire;
        end
    end

    // Record the trigger time and reload the holdoff on a trigger
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms <= '0;
            r_holdoff <= HOLD_RESET;
        end else if (calc && fire) begin
            r_last_ms <= r_now;
            r_holdoff <= n_holdoff;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - SAMPLE_W - 1)'(0), r_trigger, r_level};

endmodule

`default_nettype wire

>>> sv/mat_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mat_checker
    import mat_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty result slot always lets input in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a fresh result comes from an accepted item that passed through the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching accepted item");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind moving_average_trigger_holdoff mat_checker u_mat_checker (.*);

`default_nettype wire
